// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the ARP responder with cache.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int CACHE_AW_DEF = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int REPLY_LEN    = 42;
  localparam logic [5:0] REPLY_LAST = 6'(REPLY_LEN - 1);

  localparam logic [10:0] LEN_MIN_ETH = 11'd14;
  localparam logic [10:0] LEN_MIN_ARP = 11'(REPLY_LEN);
  localparam logic [10:0] LEN_MAX     = 11'h7ff;

  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] HTYPE_ETH = 16'h0001;
  localparam logic [15:0] PTYPE_IP  = 16'h0800;
  localparam logic [7:0]  HLEN_ETH  = 8'd6;
  localparam logic [7:0]  PLEN_IP   = 8'd4;
  localparam logic [15:0] OP_REQ    = 16'h0001;
  localparam logic [15:0] OP_REPLY  = 16'h0002;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [2:0] ST_REPLY   = 3'd0;
  localparam logic [2:0] ST_NOT_ARP = 3'd1;
  localparam logic [2:0] ST_BAD     = 3'd2;
  localparam logic [2:0] ST_UPDATED = 3'd3;
  localparam logic [2:0] ST_NO_ACT  = 3'd4;
  localparam logic [2:0] ST_LOOKUP  = 3'd5;
  localparam logic [2:0] ST_REMOVED = 3'd6;

  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  typedef enum logic [2:0] {
    CMD_STATUS,
    CMD_REPLY,
    CMD_UPDATE,
    CMD_LOOKUP,
    CMD_REMOVE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  code;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [47:0] src;
  } cmd_t;

  typedef struct packed {
    logic        v;
    logic [31:0] ip;
    logic [47:0] mac;
  } ent_t;

endpackage

// ===== design/arp_fe.sv =====
// ----------------------------------------------------------------------------
// arp_fe
// Front end: takes input transfers, parses frame bytes and queues commands.
// ----------------------------------------------------------------------------
module arp_fe import arp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] own_ip,
  input  logic        accept,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_query_ip,
  output logic        push,
  output cmd_t        cmd
);

  logic [10:0] cnt_r, cnt_nxt;
  logic [47:0] eth_r, eth_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] op_r, op_nxt;
  logic [47:0] sha_r, sha_nxt;
  logic [31:0] spa_r, spa_nxt;
  logic [31:0] tpa_r, tpa_nxt;
  logic [7:0]  b;

  assign b = in_data_byte;

  always_comb begin
    eth_nxt  = eth_r;
    kind_nxt = kind_r;
    op_nxt   = op_r;
    sha_nxt  = sha_r;
    spa_nxt  = spa_r;
    tpa_nxt  = tpa_r;
    cnt_nxt  = (cnt_r == LEN_MAX) ? cnt_r : cnt_r + 11'd1;
    if (cnt_r inside {[11'd6:11'd11]}) begin
      eth_nxt = {eth_r[39:0], b};
    end else if (cnt_r == 11'd12) begin
      if (b != ETH_ARP[15:8]) kind_nxt[0] = 1'b1;
    end else if (cnt_r == 11'd13) begin
      if (b != ETH_ARP[7:0]) kind_nxt[0] = 1'b1;
    end else if (cnt_r == 11'd14) begin
      if (b != HTYPE_ETH[15:8]) kind_nxt[1] = 1'b1;
    end else if (cnt_r == 11'd15) begin
      if (b != HTYPE_ETH[7:0]) kind_nxt[1] = 1'b1;
    end else if (cnt_r == 11'd16) begin
      if (b != PTYPE_IP[15:8]) kind_nxt[1] = 1'b1;
    end else if (cnt_r == 11'd17) begin
      if (b != PTYPE_IP[7:0]) kind_nxt[1] = 1'b1;
    end else if (cnt_r == 11'd18) begin
      if (b != HLEN_ETH) kind_nxt[1] = 1'b1;
    end else if (cnt_r == 11'd19) begin
      if (b != PLEN_IP) kind_nxt[1] = 1'b1;
    end else if (cnt_r inside {[11'd20:11'd21]}) begin
      op_nxt = {op_r[7:0], b};
    end else if (cnt_r inside {[11'd22:11'd27]}) begin
      sha_nxt = {sha_r[39:0], b};
    end else if (cnt_r inside {[11'd28:11'd31]}) begin
      spa_nxt = {spa_r[23:0], b};
    end else if (cnt_r inside {[11'd38:11'd41]}) begin
      tpa_nxt = {tpa_r[23:0], b};
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_STATUS;
    cmd.code = ST_NO_ACT;
    cmd.ip   = spa_nxt;
    cmd.mac  = sha_nxt;
    cmd.src  = eth_nxt;
    push     = 1'b0;
    case (in_mode)
      MODE_BYTE: begin
        push = accept && in_last_byte;
        if (cnt_nxt < LEN_MIN_ETH) begin
          cmd.code = ST_BAD;
        end else if (kind_nxt[0]) begin
          cmd.code = ST_NOT_ARP;
        end else if (cnt_nxt < LEN_MIN_ARP || kind_nxt[1]) begin
          cmd.code = ST_BAD;
        end else if (op_nxt == OP_REQ) begin
          if (tpa_nxt == own_ip) begin
            cmd.kind = CMD_REPLY;
            cmd.code = ST_REPLY;
          end
        end else if (op_nxt == OP_REPLY) begin
          cmd.kind = CMD_UPDATE;
          cmd.code = ST_UPDATED;
        end
      end
      MODE_LOOKUP: begin
        push     = accept;
        cmd.kind = CMD_LOOKUP;
        cmd.code = ST_LOOKUP;
        cmd.ip   = in_query_ip;
      end
      MODE_REMOVE: begin
        push     = accept;
        cmd.kind = CMD_REMOVE;
        cmd.code = ST_REMOVED;
        cmd.ip   = in_query_ip;
      end
      default: begin
        push = accept;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      eth_r  <= '0;
      kind_r <= '0;
      op_r   <= '0;
      sha_r  <= '0;
      spa_r  <= '0;
      tpa_r  <= '0;
    end else if (accept && in_mode == MODE_BYTE) begin
      if (in_last_byte) begin
        cnt_r  <= '0;
        eth_r  <= '0;
        kind_r <= '0;
        op_r   <= '0;
        sha_r  <= '0;
        spa_r  <= '0;
        tpa_r  <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        eth_r  <= eth_nxt;
        kind_r <= kind_nxt;
        op_r   <= op_nxt;
        sha_r  <= sha_nxt;
        spa_r  <= spa_nxt;
        tpa_r  <= tpa_nxt;
      end
    end
  end

endmodule

// ===== design/arp_q.sv =====
// ----------------------------------------------------------------------------
// arp_q
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module arp_q import arp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic not_empty,
  output logic full
);

  `include "assert_macros.svh"

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          buf_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign rd_cmd    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  `ASSERT_CLK(a_no_overflow, full |-> !push, "queue push while full")
  `ASSERT_NEVER(a_no_underflow, pop && !not_empty, "queue pop while empty")

endmodule

// ===== design/arp_be.sv =====
// ----------------------------------------------------------------------------
// arp_be
// Back end: clears the cache after reset, runs cache commands and streams
// reply bytes into the output register.
// ----------------------------------------------------------------------------
module arp_be import arp_pkg::*; #(
  parameter int CACHE_AW = CACHE_AW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [47:0] own_mac,
  input  logic [31:0] own_ip,
  input  cmd_t        q_cmd,
  input  logic        q_vld,
  output logic        q_pop,
  output logic        init_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_reply_byte,
  output logic        out_last_out,
  output logic        out_hit,
  output logic [47:0] out_found_mac
);

  `include "assert_macros.svh"

  localparam int ENTRIES = 1 << CACHE_AW;

  ent_t                mem [ENTRIES];
  logic [CACHE_AW:0]   clr_cnt_r;
  logic                s1_vld_r;
  cmd_t                s1_cmd_r;
  logic [5:0]          idx_r;
  ent_t                rd_ent_r;
  logic                byp_vld_r;
  ent_t                byp_ent_r;
  logic                out_valid_r;
  logic [2:0]          status_r;
  logic [7:0]          byte_r;
  logic                last_r;
  logic                hit_r;
  logic [47:0]         mac_r;

  logic                out_free, s1_step, s1_last, s1_done, hit;
  ent_t                ent, wr_data;
  logic                wr_en;
  logic [CACHE_AW-1:0] wr_addr, slot0;
  logic [335:0]        frame_vec;
  logic [5:0]          rev_idx;

  assign init_done = clr_cnt_r[CACHE_AW];
  assign out_free  = !out_valid_r || out_ready;
  assign s1_step   = s1_vld_r && out_free;
  assign s1_last   = (s1_cmd_r.kind != CMD_REPLY) || (idx_r == REPLY_LAST);
  assign s1_done   = s1_step && s1_last;
  assign q_pop     = q_vld && init_done && (!s1_vld_r || s1_done);
  assign slot0     = q_cmd.ip[CACHE_AW-1:0];
  assign ent       = byp_vld_r ? byp_ent_r : rd_ent_r;
  assign hit       = ent.v && (ent.ip == s1_cmd_r.ip);
  assign rev_idx   = REPLY_LAST - idx_r;
  assign frame_vec = {s1_cmd_r.src, own_mac, ETH_ARP, HTYPE_ETH, PTYPE_IP, HLEN_ETH,
                      PLEN_IP, OP_REPLY, own_mac, own_ip, s1_cmd_r.mac, s1_cmd_r.ip};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_cmd_r.ip[CACHE_AW-1:0];
    wr_data = '0;
    if (!init_done) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r[CACHE_AW-1:0];
    end else if (s1_done && s1_cmd_r.kind == CMD_UPDATE) begin
      wr_en   = 1'b1;
      wr_data = {1'b1, s1_cmd_r.ip, s1_cmd_r.mac};
    end else if (s1_done && s1_cmd_r.kind == CMD_REMOVE && hit) begin
      wr_en   = 1'b1;
      wr_data = {1'b0, ent.ip, ent.mac};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (q_pop) rd_ent_r <= mem[slot0];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r  <= q_cmd;
      byp_ent_r <= wr_data;
    end
    if (s1_step) begin
      status_r <= s1_cmd_r.code;
      byte_r   <= (s1_cmd_r.kind == CMD_REPLY) ? frame_vec[{rev_idx, 3'b000} +: 8] : 8'd0;
      last_r   <= s1_last;
      hit_r    <= (s1_cmd_r.kind == CMD_LOOKUP || s1_cmd_r.kind == CMD_REMOVE) && hit;
      mac_r    <= (s1_cmd_r.kind == CMD_LOOKUP && hit) ? ent.mac : 48'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      idx_r       <= '0;
      byp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!init_done) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (q_pop) begin
        s1_vld_r  <= 1'b1;
        idx_r     <= '0;
        byp_vld_r <= wr_en && (wr_addr == slot0);
      end else begin
        if (s1_done) s1_vld_r <= 1'b0;
        if (s1_step && !s1_last) idx_r <= idx_r + 1'b1;
      end
      if (s1_step) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_reply_byte = byte_r;
  assign out_last_out   = last_r;
  assign out_hit        = hit_r;
  assign out_found_mac  = mac_r;

  `ASSERT_CLK(a_idle_in_clear, !init_done |-> !q_pop && !s1_vld_r, "work during clear")
  `ASSERT_CLK(a_idx_range, s1_vld_r |-> idx_r <= REPLY_LAST, "reply index out of range")

endmodule

// ===== design/arp_responder_with_cache_top.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_cache_top
// ARP responder with a direct-mapped ARP cache of 2**CACHE_AW entries.
// ----------------------------------------------------------------------------
// Frame bytes, lookups and removes are taken one per cycle while in_ready is
// high. After reset the cache is cleared and in_ready stays low until all
// 2**CACHE_AW slots are clear. A frame's last byte, a lookup, a remove or a
// mode-3 transfer queues one command (queue of 4); the back end runs one
// command per cycle unless out_ready stalls; a reply holds it while the 42
// reply bytes stream out. Cache slot is the low CACHE_AW bits of the IP.
module arp_responder_with_cache_top import arp_pkg::*; #(
  parameter int CACHE_AW = CACHE_AW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_query_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_reply_byte,
  output logic        out_last_out,
  output logic        out_hit,
  output logic [47:0] out_found_mac
);

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic        init_done, q_full, q_vld, q_pop, push;
  cmd_t        wr_cmd, rd_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_MAC: own_mac_r <= cfg_wdata;
        CFG_OWN_IP:  own_ip_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign in_ready = init_done && !q_full;

  arp_fe u_fe (
    .clk          (clk),
    .rst_n        (rst_n),
    .own_ip       (own_ip_r),
    .accept       (in_valid && in_ready),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_query_ip  (in_query_ip),
    .push         (push),
    .cmd          (wr_cmd)
  );

  arp_q u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (wr_cmd),
    .pop       (q_pop),
    .rd_cmd    (rd_cmd),
    .not_empty (q_vld),
    .full      (q_full)
  );

  arp_be #(.CACHE_AW(CACHE_AW)) u_be (
    .clk            (clk),
    .rst_n          (rst_n),
    .own_mac        (own_mac_r),
    .own_ip         (own_ip_r),
    .q_cmd          (rd_cmd),
    .q_vld          (q_vld),
    .q_pop          (q_pop),
    .init_done      (init_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_reply_byte (out_reply_byte),
    .out_last_out   (out_last_out),
    .out_hit        (out_hit),
    .out_found_mac  (out_found_mac)
  );

endmodule
